// ===== hw/rtl/cpa_pkg.sv =====
// shared types, codes and sizes of the contiguous partition allocator
// no dependencies
package cpa_pkg;

  localparam int MAX_BLOCKS = 32;
  localparam int ADDR_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int LEN_W      = ADDR_BITS + 1;
  localparam int OWNER_W    = 8;
  localparam int SIZE_W     = 17;
  localparam int CFG_W      = 17;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;
  localparam logic [1:0] OP_REINIT  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NOOWNER = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic CFG_TOTAL_SIZE = 1'b0;
  localparam logic CFG_FIT_MODE   = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start_addr;
    logic [ADDR_BITS-1:0] end_addr;
    logic [OWNER_W-1:0]   owner;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LO,
    CELL_FROM_HI
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    entry_t   data;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/cpa_req_if.sv =====
// request channel: valid, ready and one operation word
// depends on cpa_pkg
interface cpa_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [cpa_pkg::SIZE_W-1:0]  request_size;
  logic [cpa_pkg::OWNER_W-1:0] owner_id;
  modport source (output valid, operation, request_size, owner_id, input ready);
  modport sink   (input valid, operation, request_size, owner_id, output ready);
endinterface

// ===== hw/rtl/cpa_rsp_if.sv =====
// response channel: valid, ready and one result word
// depends on cpa_pkg
interface cpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [cpa_pkg::ADDR_BITS-1:0] base_address;
  logic [5:0]                    blocks_in_use;
  modport source (output valid, status, base_address, blocks_in_use, input ready);
  modport sink   (input valid, status, base_address, blocks_in_use, output ready);
endinterface

// ===== hw/rtl/cpa_cell.sv =====
// one table entry of the block chain: holds, loads or takes a neighbor entry
// depends on cpa_pkg
module cpa_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpa_pkg::cell_ctl_t ctl_i,
  input  cpa_pkg::entry_t    lo_i,
  input  cpa_pkg::entry_t    hi_i,
  output cpa_pkg::entry_t    entry_o
);
  import cpa_pkg::*;

  entry_t entry_q, entry_d;

  always_comb begin
    case (ctl_i.op)
      CELL_LOAD:    entry_d = ctl_i.data;
      CELL_FROM_LO: entry_d = lo_i;
      CELL_FROM_HI: entry_d = hi_i;
      default:      entry_d = entry_q;
    endcase
  end

  // reset gives a free block spanning the full address range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '{start_addr: '0, end_addr: '1, owner: '0};
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
endmodule

// ===== hw/rtl/contiguous_partition_allocator_top.sv =====
// contiguous partition allocator: controller plus a chain of table cells
// sequence: allocate scans one entry per cycle, then splits the chosen entry; release scans,
// then merges with the next and then the previous entry; compact scans once for a free
// entry and again to pack; reinit and rejected requests go straight to the result word
// throughput: one operation at a time, next word taken in the cycle after the result
// reset: asynchronous, one free block of 65536 units, first fit
module contiguous_partition_allocator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [cpa_pkg::CFG_W-1:0]   cfg_data_i,
  cpa_req_if.sink                     req,
  cpa_rsp_if.source                   rsp
);
  import cpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ALLOC_FIN, S_REL_NEXT, S_REL_PREV, S_COMP, S_COMP_END, S_DONE
  } state_e;

  state_e               state_q;
  logic [CFG_W-1:0]     total_size_q;
  logic [1:0]           fit_mode_q;
  logic [1:0]           op_q;
  logic [SIZE_W-1:0]    size_q;
  logic [OWNER_W-1:0]   owner_q;
  logic [CNT_W-1:0]     count_q, idx_q, n_q;
  logic [IDX_W-1:0]     loc_q;
  logic                 found_q, any_free_q;
  logic [LEN_W-1:0]     best_q;
  logic [ADDR_BITS-1:0] cursor_q, top_q;
  logic [1:0]           res_status_q;
  logic [ADDR_BITS-1:0] res_base_q;
  logic                 out_valid_q;
  logic [1:0]           out_status_q;
  logic [ADDR_BITS-1:0] out_base_q;
  logic [5:0]           out_count_q;

  entry_t    cells [MAX_BLOCKS];
  cell_ctl_t ctl   [MAX_BLOCKS];

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    cpa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[g]),
      .lo_i   (cells[(g == 0) ? 0 : g - 1]),
      .hi_i   (cells[(g == MAX_BLOCKS - 1) ? g : g + 1]),
      .entry_o(cells[g])
    );
  end

  // read ports into the chain
  entry_t           cur, at_loc, nxt, prv;
  logic [LEN_W-1:0] cur_len, loc_len;
  logic             last, hit, better;
  logic [IDX_W-1:0] loc_p1, loc_m1;

  assign loc_p1  = loc_q + IDX_W'(1);
  assign loc_m1  = loc_q - IDX_W'(1);
  assign cur     = cells[idx_q[IDX_W-1:0]];
  assign at_loc  = cells[loc_q];
  assign nxt     = cells[loc_p1];
  assign prv     = cells[loc_m1];
  assign cur_len = LEN_W'(cur.end_addr) - LEN_W'(cur.start_addr) + LEN_W'(1);
  assign loc_len = LEN_W'(at_loc.end_addr) - LEN_W'(at_loc.start_addr) + LEN_W'(1);
  assign last    = (idx_q == count_q - CNT_W'(1));
  assign hit     = (cur.owner == '0) && (cur_len >= LEN_W'(size_q));
  always_comb begin
    case (fit_mode_q)
      FIT_BEST:  better = !found_q || (cur_len < best_q);
      FIT_WORST: better = !found_q || (cur_len > best_q);
      default:   better = !found_q;
    endcase
  end

  // reinit end address, total size clamped to one .. 2^ADDR_BITS
  logic [LEN_W-1:0] tsize;
  always_comb begin
    tsize = LEN_W'(total_size_q);
    if (tsize == '0) tsize = LEN_W'(1);
    else if (tsize > LEN_W'(1 << ADDR_BITS)) tsize = LEN_W'(1 << ADDR_BITS);
  end
  logic [ADDR_BITS-1:0] reinit_end;
  assign reinit_end = ADDR_BITS'(tsize - LEN_W'(1));

  logic merge_next, merge_prev, exact;
  assign merge_next = (CNT_W'(loc_q) + CNT_W'(1) < count_q) && (nxt.owner == '0);
  assign merge_prev = (loc_q != '0) && (prv.owner == '0);
  assign exact      = (loc_len == LEN_W'(size_q));

  logic [ADDR_BITS-1:0] split_end, comp_end;
  assign split_end = ADDR_BITS'(LEN_W'(at_loc.start_addr) + LEN_W'(size_q) - LEN_W'(1));
  assign comp_end  = cursor_q + (cur.end_addr - cur.start_addr);

  // per-cell commands
  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      ctl[i].op   = CELL_HOLD;
      ctl[i].data = cells[i];
    end
    case (state_q)
      S_IDLE: begin
        if (req.valid && req.operation == OP_REINIT) begin
          ctl[0].op   = CELL_LOAD;
          ctl[0].data = '{start_addr: '0, end_addr: reinit_end, owner: '0};
        end
      end
      S_ALLOC_FIN: begin
        if (found_q) begin
          if (exact) begin
            ctl[loc_q].op         = CELL_LOAD;
            ctl[loc_q].data       = at_loc;
            ctl[loc_q].data.owner = owner_q;
          end else if (count_q != CNT_W'(MAX_BLOCKS)) begin
            for (int i = 0; i < MAX_BLOCKS; i++)
              if (i > int'(loc_q) + 1) ctl[i].op = CELL_FROM_LO;
            ctl[loc_q].op   = CELL_LOAD;
            ctl[loc_q].data = '{start_addr: at_loc.start_addr, end_addr: split_end,
                                owner: owner_q};
            ctl[loc_p1].op   = CELL_LOAD;
            ctl[loc_p1].data = '{start_addr: split_end + ADDR_BITS'(1),
                                 end_addr: at_loc.end_addr, owner: '0};
          end
        end
      end
      S_REL_NEXT: begin
        if (merge_next) begin
          for (int i = 0; i < MAX_BLOCKS - 1; i++)
            if (i > int'(loc_q)) ctl[i].op = CELL_FROM_HI;
          ctl[loc_q].op   = CELL_LOAD;
          ctl[loc_q].data = '{start_addr: at_loc.start_addr, end_addr: nxt.end_addr,
                              owner: '0};
        end else begin
          ctl[loc_q].op         = CELL_LOAD;
          ctl[loc_q].data       = at_loc;
          ctl[loc_q].data.owner = '0;
        end
      end
      S_REL_PREV: begin
        if (merge_prev) begin
          for (int i = 0; i < MAX_BLOCKS - 1; i++)
            if (i >= int'(loc_q)) ctl[i].op = CELL_FROM_HI;
          ctl[loc_m1].op   = CELL_LOAD;
          ctl[loc_m1].data = '{start_addr: prv.start_addr, end_addr: at_loc.end_addr,
                               owner: '0};
        end
      end
      S_COMP: begin
        if (cur.owner != '0) begin
          ctl[n_q[IDX_W-1:0]].op   = CELL_LOAD;
          ctl[n_q[IDX_W-1:0]].data = '{start_addr: cursor_q, end_addr: comp_end,
                                       owner: cur.owner};
        end
      end
      S_COMP_END: begin
        ctl[n_q[IDX_W-1:0]].op   = CELL_LOAD;
        ctl[n_q[IDX_W-1:0]].data = '{start_addr: cursor_q, end_addr: top_q, owner: '0};
      end
      default: ;
    endcase
  end

  assign req.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      total_size_q <= CFG_W'(65536);
      fit_mode_q   <= '0;
      count_q      <= CNT_W'(1);
      out_valid_q  <= 1'b0;
      op_q <= '0; size_q <= '0; owner_q <= '0; idx_q <= '0; n_q <= '0; loc_q <= '0;
      found_q <= 1'b0; any_free_q <= 1'b0; best_q <= '0; cursor_q <= '0; top_q <= '0;
      res_status_q <= ST_OK; res_base_q <= '0;
      out_status_q <= ST_OK; out_base_q <= '0; out_count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TOTAL_SIZE) total_size_q <= cfg_data_i;
        else                             fit_mode_q   <= cfg_data_i[1:0];
      end
      // in S_DONE the output register is reloaded below
      if (rsp.valid && rsp.ready && state_q != S_DONE) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            op_q         <= req.operation;
            size_q       <= req.request_size;
            owner_q      <= req.owner_id;
            idx_q        <= '0;
            found_q      <= 1'b0;
            any_free_q   <= 1'b0;
            res_status_q <= ST_OK;
            res_base_q   <= '0;
            cursor_q     <= cells[0].start_addr;
            state_q      <= S_SCAN;
            case (req.operation)
              OP_ALLOC: begin
                if (req.owner_id == '0) begin
                  res_status_q <= ST_NOOWNER; state_q <= S_DONE;
                end else if (req.request_size == '0) begin
                  res_status_q <= ST_NOFIT; state_q <= S_DONE;
                end
              end
              OP_RELEASE: begin
                if (req.owner_id == '0) begin
                  res_status_q <= ST_NOOWNER; state_q <= S_DONE;
                end
              end
              OP_REINIT: begin
                count_q <= CNT_W'(1);
                state_q <= S_DONE;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          idx_q <= idx_q + CNT_W'(1);
          case (op_q)
            OP_ALLOC: begin
              if (hit && better) begin
                found_q <= 1'b1;
                loc_q   <= idx_q[IDX_W-1:0];
                best_q  <= cur_len;
              end
              if (last || (hit && fit_mode_q != FIT_BEST && fit_mode_q != FIT_WORST))
                state_q <= S_ALLOC_FIN;
            end
            OP_RELEASE: begin
              if (cur.owner == owner_q) begin
                loc_q   <= idx_q[IDX_W-1:0];
                state_q <= S_REL_NEXT;
              end else if (last) begin
                res_status_q <= ST_NOOWNER;
                state_q      <= S_DONE;
              end
            end
            default: begin
              if (cur.owner == '0) any_free_q <= 1'b1;
              if (last) begin
                top_q <= cur.end_addr;
                idx_q <= '0;
                n_q   <= '0;
                state_q <= (any_free_q || cur.owner == '0) ? S_COMP : S_DONE;
              end
            end
          endcase
        end
        S_ALLOC_FIN: begin
          state_q <= S_DONE;
          if (!found_q) begin
            res_status_q <= ST_NOFIT;
          end else if (exact) begin
            res_base_q <= at_loc.start_addr;
          end else if (count_q == CNT_W'(MAX_BLOCKS)) begin
            res_status_q <= ST_FULL;
          end else begin
            res_base_q <= at_loc.start_addr;
            count_q    <= count_q + CNT_W'(1);
          end
        end
        S_REL_NEXT: begin
          if (merge_next) count_q <= count_q - CNT_W'(1);
          state_q <= S_REL_PREV;
        end
        S_REL_PREV: begin
          if (merge_prev) count_q <= count_q - CNT_W'(1);
          state_q <= S_DONE;
        end
        S_COMP: begin
          idx_q <= idx_q + CNT_W'(1);
          if (cur.owner != '0) begin
            n_q      <= n_q + CNT_W'(1);
            cursor_q <= comp_end + ADDR_BITS'(1);
          end
          if (last) state_q <= S_COMP_END;
        end
        S_COMP_END: begin
          count_q <= n_q + CNT_W'(1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || rsp.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_base_q   <= res_base_q;
            out_count_q  <= 6'(count_q);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.status        = out_status_q;
  assign rsp.base_address  = out_base_q;
  assign rsp.blocks_in_use = out_count_q;
endmodule

// ===== hw/rtl/cpa_checker.sv =====
// port-level checks of the allocator's response channel
// depends on cpa_pkg; bound to contiguous_partition_allocator_top
module cpa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [1:0]                    rsp_status,
  input logic [cpa_pkg::ADDR_BITS-1:0] rsp_base,
  input logic [5:0]                    rsp_count
);
  import cpa_pkg::*;

  // a waiting word keeps its status and count until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count))
    else $error("response word changed while stalled");

  a_base_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status != ST_OK |-> rsp_base == '0)
    else $error("failed operation reports a base address");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_count != '0 && rsp_count <= 6'(MAX_BLOCKS))
    else $error("block count out of range");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status == ST_FULL |-> rsp_count == 6'(MAX_BLOCKS))
    else $error("table full reported with free entries");
endmodule

bind contiguous_partition_allocator_top cpa_checker u_cpa_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_status(rsp.status),
  .rsp_base  (rsp.base_address),
  .rsp_count (rsp.blocks_in_use)
);
